// File: design/jrt_pkg.sv
// ----------------------------------------------------------------------------
// jrt_pkg
// Shared constants, codes and controller/datapath interface types of the
// jagged row table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package jrt_pkg;

	localparam int ROW_CAPACITY_DEF = 10;
	localparam int MAX_ROWS_DEF     = 64;

	localparam logic [2:0] CMD_FIND   = 3'd0;
	localparam logic [2:0] CMD_MODIFY = 3'd1;
	localparam logic [2:0] CMD_APPEND = 3'd2;
	localparam logic [2:0] CMD_ZERO   = 3'd3;
	localparam logic [2:0] CMD_REMOVE = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_F_LENCHK, S_F_CMP, S_CHK, S_M_WR,
		S_R_RD, S_R_WR, S_C_RD, S_C_WR, S_L_RD, S_L_WR,
		S_A_CHK, S_A_WR, S_DONE
	} state_t;

	typedef enum logic [1:0] {LRS_I, LRS_LAST, LRS_REQ, LRS_INEXT} len_rsel_t;
	typedef enum logic [1:0] {CRS_ADDR, CRS_NEXT, CRS_ROW} cell_rsel_t;
	typedef enum logic [2:0] {
		AO_HOLD, AO_REQ, AO_INC, AO_NEXTROW, AO_ROWBASE, AO_APP_LAST, AO_APP_NEW
	} addr_op_t;
	typedef enum logic [1:0] {J_HOLD, J_ZERO, J_LOADC, J_INC} j_op_t;
	typedef enum logic [1:0] {I_HOLD, I_INC, I_LOADR} i_op_t;
	typedef enum logic [1:0] {WS_V, WS_ZERO, WS_RD} cell_wsel_t;
	typedef enum logic [2:0] {LW_NONE, LW_DEC, LW_INC_LAST, LW_NEW, LW_COPY} len_wop_t;
	typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_t;
	typedef enum logic [2:0] {
		RES_HOLD, RES_OK, RES_NOTFOUND, RES_RANGE, RES_FULL, RES_HIT, RES_OLD
	} res_op_t;

	typedef struct packed {
		logic       load;
		len_rsel_t  len_rsel;
		cell_rsel_t cell_rsel;
		logic       len_cap;
		addr_op_t   addr_op;
		j_op_t      j_op;
		i_op_t      i_op;
		logic       cell_we;
		cell_wsel_t cell_wsel;
		len_wop_t   len_wop;
		cnt_op_t    cnt_op;
		logic       lim_load;
		res_op_t    res_op;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       req_ok;
		logic       app_fits;
		logic       full;
		logic       row_end;
		logic       hit;
		logic       more;
		logic       last_one;
		logic       copy_more;
		logic       lcopy_more;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: design/jagged_row_table_engine.sv
// ----------------------------------------------------------------------------
// jagged_row_table_engine
// Table of packed rows of signed 32-bit entries with find, modify, append,
// zero and remove requests, one result per request.
// ----------------------------------------------------------------------------
// Usage: a request (cmd, row_index, col_index, data_value) is taken when
// in_valid is high and in_stall is low. Exactly one result (status,
// found_row, found_col, old_value) follows on the output channel, taken when
// out_valid is high and out_stall is low. Requests are handled one at a
// time: in_stall stays high from acceptance until the result has been moved
// into the output register.
// Find reads the entries row by row through the single read port of the entry
// memory. Remove shifts each entry after the removed one within the row and,
// when the row empties, every entry of each later row and each later row
// length, as every move is a read followed by a write.
// Reset clears the row count and the handshake state only. Entries and row
// lengths beyond the used part of the table are never read, so no clearing
// pass is needed and the block takes requests as soon as reset is released.
// A stalled receiver holds the result in the output register; the next
// request is still accepted and runs, and waits at its end until the output
// register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module jagged_row_table_engine
	import jrt_pkg::*;
#(
	parameter int ROW_CAPACITY = ROW_CAPACITY_DEF,
	parameter int MAX_ROWS     = MAX_ROWS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic        [2:0]  cmd,
	input  wire logic        [5:0]  row_index,
	input  wire logic        [3:0]  col_index,
	input  wire logic signed [31:0] data_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic             [1:0]  status,
	output logic             [5:0]  found_row,
	output logic             [3:0]  found_col,
	output logic signed      [31:0] old_value
);

	// Command and status bundles between the sequencer and the datapath.
	dp_cmd_t  dpc;
	dp_stat_t stat;

	jrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.dpc       (dpc)
	);

	jrt_datapath #(
		.ROW_CAPACITY (ROW_CAPACITY),
		.MAX_ROWS     (MAX_ROWS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.dpc        (dpc),
		.stat       (stat),
		.cmd        (cmd),
		.row_index  (row_index),
		.col_index  (col_index),
		.data_value (data_value),
		.status     (status),
		.found_row  (found_row),
		.found_col  (found_col),
		.old_value  (old_value)
	);

endmodule

`default_nettype wire

// File: design/jrt_ctrl.sv
// ----------------------------------------------------------------------------
// jrt_ctrl
// Controller state machine: sequences each request through the datapath and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module jrt_ctrl
	import jrt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  wire logic     out_stall,
	input  wire dp_stat_t stat,
	output dp_cmd_t       dpc
);

	state_t state_q, state_nx;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (dpc.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != S_IDLE);

	always_comb begin
		state_nx = state_q;
		dpc      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					dpc.load = 1'b1;
					state_nx = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.cmd)
					CMD_FIND: begin
						dpc.len_rsel = LRS_I;
						state_nx     = S_F_LENCHK;
					end
					CMD_MODIFY, CMD_ZERO, CMD_REMOVE: begin
						dpc.len_rsel = LRS_REQ;
						dpc.addr_op  = AO_REQ;
						state_nx     = S_CHK;
					end
					CMD_APPEND: begin
						dpc.len_rsel = LRS_LAST;
						state_nx     = S_A_CHK;
					end
					default: begin
						dpc.res_op = RES_RANGE;
						state_nx   = S_DONE;
					end
				endcase
			end
			S_F_LENCHK: begin
				if (stat.row_end) begin
					dpc.res_op = RES_NOTFOUND;
					state_nx   = S_DONE;
				end else begin
					dpc.len_cap   = 1'b1;
					dpc.cell_rsel = CRS_ADDR;
					state_nx      = S_F_CMP;
				end
			end
			S_F_CMP: begin
				if (stat.hit) begin
					dpc.res_op = RES_HIT;
					state_nx   = S_DONE;
				end else if (stat.more) begin
					dpc.cell_rsel = CRS_NEXT;
					dpc.addr_op   = AO_INC;
					dpc.j_op      = J_INC;
				end else begin
					dpc.addr_op  = AO_NEXTROW;
					dpc.i_op     = I_INC;
					dpc.j_op     = J_ZERO;
					dpc.len_rsel = LRS_INEXT;
					state_nx     = S_F_LENCHK;
				end
			end
			S_CHK: begin
				if (!stat.req_ok) begin
					dpc.res_op = RES_RANGE;
					state_nx   = S_DONE;
				end else begin
					dpc.len_cap = 1'b1;
					unique case (stat.cmd)
						CMD_MODIFY: begin
							dpc.cell_rsel = CRS_ADDR;
							state_nx      = S_M_WR;
						end
						CMD_ZERO: begin
							dpc.cell_we   = 1'b1;
							dpc.cell_wsel = WS_ZERO;
							dpc.res_op    = RES_OK;
							state_nx      = S_DONE;
						end
						default: begin
							dpc.j_op = J_LOADC;
							state_nx = S_R_RD;
						end
					endcase
				end
			end
			S_M_WR: begin
				dpc.cell_we   = 1'b1;
				dpc.cell_wsel = WS_V;
				dpc.res_op    = RES_OLD;
				state_nx      = S_DONE;
			end
			S_R_RD: begin
				if (stat.more) begin
					dpc.cell_rsel = CRS_NEXT;
					state_nx      = S_R_WR;
				end else begin
					dpc.len_wop = LW_DEC;
					if (stat.last_one) begin
						dpc.addr_op  = AO_ROWBASE;
						dpc.i_op     = I_LOADR;
						dpc.lim_load = 1'b1;
						state_nx     = S_C_RD;
					end else begin
						dpc.res_op = RES_OK;
						state_nx   = S_DONE;
					end
				end
			end
			S_R_WR: begin
				dpc.cell_we   = 1'b1;
				dpc.cell_wsel = WS_RD;
				dpc.addr_op   = AO_INC;
				dpc.j_op      = J_INC;
				state_nx      = S_R_RD;
			end
			S_C_RD: begin
				if (stat.copy_more) begin
					dpc.cell_rsel = CRS_ROW;
					state_nx      = S_C_WR;
				end else begin
					state_nx = S_L_RD;
				end
			end
			S_C_WR: begin
				dpc.cell_we   = 1'b1;
				dpc.cell_wsel = WS_RD;
				dpc.addr_op   = AO_INC;
				state_nx      = S_C_RD;
			end
			S_L_RD: begin
				if (stat.lcopy_more) begin
					dpc.len_rsel = LRS_INEXT;
					state_nx     = S_L_WR;
				end else begin
					dpc.cnt_op = CNT_DEC;
					dpc.res_op = RES_OK;
					state_nx   = S_DONE;
				end
			end
			S_L_WR: begin
				dpc.len_wop = LW_COPY;
				dpc.i_op    = I_INC;
				state_nx    = S_L_RD;
			end
			S_A_CHK: begin
				if (stat.app_fits) begin
					dpc.addr_op = AO_APP_LAST;
					dpc.len_wop = LW_INC_LAST;
					state_nx    = S_A_WR;
				end else if (stat.full) begin
					dpc.res_op = RES_FULL;
					state_nx   = S_DONE;
				end else begin
					dpc.addr_op = AO_APP_NEW;
					dpc.len_wop = LW_NEW;
					dpc.cnt_op  = CNT_INC;
					state_nx    = S_A_WR;
				end
			end
			S_A_WR: begin
				dpc.cell_we   = 1'b1;
				dpc.cell_wsel = WS_V;
				dpc.res_op    = RES_OK;
				state_nx      = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					dpc.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// File: design/jrt_datapath.sv
// ----------------------------------------------------------------------------
// jrt_datapath
// Entry and row-length memories, pointers, row count and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module jrt_datapath
	import jrt_pkg::*;
#(
	parameter int ROW_CAPACITY = ROW_CAPACITY_DEF,
	parameter int MAX_ROWS     = MAX_ROWS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_cmd_t            dpc,
	output dp_stat_t                stat,
	input  wire logic        [2:0]  cmd,
	input  wire logic        [5:0]  row_index,
	input  wire logic        [3:0]  col_index,
	input  wire logic signed [31:0] data_value,
	output logic             [1:0]  status,
	output logic             [5:0]  found_row,
	output logic             [3:0]  found_col,
	output logic signed      [31:0] old_value
);

	localparam int CT  = ROW_CAPACITY * MAX_ROWS;
	localparam int AW  = (CT > 1) ? $clog2(CT) : 1;
	localparam int BW  = $clog2(CT + 1);
	localparam int QW  = (BW > 11) ? BW : 11;
	localparam int CW  = $clog2(MAX_ROWS + 1);
	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int LW  = $clog2(ROW_CAPACITY + 1);
	localparam int LW1 = LW + 1;
	localparam int CMW = (LW1 > 4) ? LW1 : 4;
	localparam int RCW = (CW > 6) ? CW : 6;

	logic [31:0] cell_mem [CT];
	logic [LW-1:0] len_mem [MAX_ROWS];

	logic [2:0]  cmd_q;
	logic [5:0]  r_q;
	logic [3:0]  c_q;
	logic [31:0] v_q;
	logic [CW-1:0] count_q, i_q;
	logic [LW-1:0] j_q, len_q, len_rd_q;
	logic [AW-1:0] addr_q, base_q;
	logic [BW-1:0] lim_q;
	logic [31:0] cell_rd_q;
	logic [1:0]  res_status_q, out_status_q;
	logic [5:0]  res_row_q, out_row_q;
	logic [3:0]  res_col_q, out_col_q;
	logic [31:0] res_old_q, out_old_q;

	logic [BW-1:0] cnt_base, next_base;
	logic [QW-1:0] req_base, req_full;
	logic [RW-1:0] len_raddr, len_waddr;
	logic [LW-1:0] len_wdata;
	logic          len_we;
	logic [AW-1:0] cell_raddr;
	logic [31:0]   cell_wdata;
	logic [LW1-1:0] j_next;

	assign cnt_base  = BW'(count_q) * BW'(ROW_CAPACITY);
	assign next_base = BW'(base_q) + BW'(ROW_CAPACITY);
	assign req_base  = QW'(r_q) * QW'(ROW_CAPACITY);
	assign req_full  = req_base + QW'(c_q);
	assign j_next    = LW1'(j_q) + LW1'(1);

	always_comb begin
		unique case (dpc.len_rsel)
			LRS_I:     len_raddr = RW'(i_q);
			LRS_LAST:  len_raddr = RW'(count_q - CW'(1));
			LRS_REQ:   len_raddr = RW'(r_q);
			LRS_INEXT: len_raddr = RW'(i_q + CW'(1));
			default:   len_raddr = RW'(i_q);
		endcase
		unique case (dpc.cell_rsel)
			CRS_NEXT: cell_raddr = addr_q + AW'(1);
			CRS_ROW:  cell_raddr = AW'(BW'(addr_q) + BW'(ROW_CAPACITY));
			default:  cell_raddr = addr_q;
		endcase
		unique case (dpc.cell_wsel)
			WS_ZERO: cell_wdata = '0;
			WS_RD:   cell_wdata = cell_rd_q;
			default: cell_wdata = v_q;
		endcase
		len_we = 1'b1;
		unique case (dpc.len_wop)
			LW_DEC: begin
				len_waddr = RW'(r_q);
				len_wdata = len_q - LW'(1);
			end
			LW_INC_LAST: begin
				len_waddr = RW'(count_q - CW'(1));
				len_wdata = len_rd_q + LW'(1);
			end
			LW_NEW: begin
				len_waddr = RW'(count_q);
				len_wdata = LW'(1);
			end
			LW_COPY: begin
				len_waddr = RW'(i_q);
				len_wdata = len_rd_q;
			end
			default: begin
				len_we    = 1'b0;
				len_waddr = RW'(i_q);
				len_wdata = len_rd_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dpc.cell_we)
			cell_mem[addr_q] <= cell_wdata;
		cell_rd_q <= cell_mem[cell_raddr];
		if (len_we)
			len_mem[len_waddr] <= len_wdata;
		len_rd_q <= len_mem[len_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (dpc.cnt_op)
				CNT_INC: count_q <= count_q + CW'(1);
				CNT_DEC: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (dpc.load) begin
			cmd_q  <= cmd;
			r_q    <= row_index;
			c_q    <= col_index;
			v_q    <= data_value;
			i_q    <= '0;
			j_q    <= '0;
			addr_q <= '0;
			base_q <= '0;
		end else begin
			case (dpc.addr_op)
				AO_REQ:      addr_q <= AW'(req_full);
				AO_INC:      addr_q <= addr_q + AW'(1);
				AO_NEXTROW: begin
					addr_q <= AW'(next_base);
					base_q <= AW'(next_base);
				end
				AO_ROWBASE:  addr_q <= AW'(req_base);
				AO_APP_LAST: addr_q <= AW'(cnt_base - BW'(ROW_CAPACITY) + BW'(len_rd_q));
				AO_APP_NEW:  addr_q <= AW'(cnt_base);
				default:     addr_q <= addr_q;
			endcase
			case (dpc.j_op)
				J_ZERO:  j_q <= '0;
				J_LOADC: j_q <= LW'(c_q);
				J_INC:   j_q <= j_q + LW'(1);
				default: j_q <= j_q;
			endcase
			case (dpc.i_op)
				I_INC:   i_q <= i_q + CW'(1);
				I_LOADR: i_q <= CW'(r_q);
				default: i_q <= i_q;
			endcase
		end
		if (dpc.len_cap)
			len_q <= len_rd_q;
		if (dpc.lim_load)
			lim_q <= cnt_base - BW'(ROW_CAPACITY);
		case (dpc.res_op)
			RES_HOLD: ;
			RES_HIT: begin
				res_status_q <= ST_OK;
				res_row_q    <= 6'(i_q);
				res_col_q    <= 4'(j_q);
				res_old_q    <= '0;
			end
			RES_OLD: begin
				res_status_q <= ST_OK;
				res_row_q    <= '0;
				res_col_q    <= '0;
				res_old_q    <= cell_rd_q;
			end
			default: begin
				case (dpc.res_op)
					RES_NOTFOUND: res_status_q <= ST_NOTFOUND;
					RES_RANGE:    res_status_q <= ST_RANGE;
					RES_FULL:     res_status_q <= ST_FULL;
					default:      res_status_q <= ST_OK;
				endcase
				res_row_q <= '0;
				res_col_q <= '0;
				res_old_q <= '0;
			end
		endcase
		if (dpc.out_load) begin
			out_status_q <= res_status_q;
			out_row_q    <= res_row_q;
			out_col_q    <= res_col_q;
			out_old_q    <= res_old_q;
		end
	end

	always_comb begin
		stat.cmd        = cmd_q;
		stat.req_ok     = (RCW'(r_q) < RCW'(count_q)) && (CMW'(c_q) < CMW'(len_rd_q));
		stat.app_fits   = (count_q != '0) && (len_rd_q < LW'(ROW_CAPACITY));
		stat.full       = (count_q >= CW'(MAX_ROWS));
		stat.row_end    = (i_q >= count_q);
		stat.hit        = (cell_rd_q == v_q);
		stat.more       = (j_next < LW1'(len_q));
		stat.last_one   = (len_q == LW'(1));
		stat.copy_more  = (BW'(addr_q) < lim_q);
		stat.lcopy_more = ((i_q + CW'(1)) < count_q);
	end

	assign status    = out_status_q;
	assign found_row = out_row_q;
	assign found_col = out_col_q;
	assign old_value = out_old_q;

endmodule

`default_nettype wire

// File: design/jrt_checker.sv
// ----------------------------------------------------------------------------
// jrt_checker
// Port-level checks of the jagged row table engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jrt_checker
	import jrt_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [2:0]  cmd,
	input wire logic [5:0]  row_index,
	input wire logic [3:0]  col_index,
	input wire logic [31:0] data_value,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  status,
	input wire logic [5:0]  found_row,
	input wire logic [3:0]  found_col,
	input wire logic [31:0] old_value
);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while another was in flight");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(old_value))
		else $error("stalled result changed or dropped");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> found_row == '0 && found_col == '0)
		else $error("position reported with a failing status");

	a_fail_no_old: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> old_value == '0)
		else $error("old value reported with a failing status");

endmodule

bind jagged_row_table_engine jrt_checker u_chk (.*);

`default_nettype wire

// File: tb/tb_jagged_row_table_engine.sv
// ----------------------------------------------------------------------------
// tb_jagged_row_table_engine
// Self-checking testbench for the jagged row table engine. A short table of
// directed requests is followed by random requests that fill the table
// to the full condition and then drain it again. Every result is checked
// against an internal table model, field by field. Both sides idle and
// stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_jagged_row_table_engine
	import jrt_pkg::*;
;

	localparam int CAP       = ROW_CAPACITY_DEF;
	localparam int ROWS      = MAX_ROWS_DEF;
	localparam int N_RANDOM  = 900;
	localparam int N_DIRECT  = 24;

	// The command code space holds three values past the last operation.
	localparam logic [2:0] CMD_BAD5 = 3'd5;
	localparam logic [2:0] CMD_BAD6 = 3'd6;
	localparam logic [2:0] CMD_BAD7 = 3'd7;

	typedef struct {
		logic [1:0]  status;
		logic [5:0]  found_row;
		logic [3:0]  found_col;
		logic [31:0] old_value;
	} outcome_t;

	typedef struct {
		logic [2:0]  cmd;
		logic [5:0]  row_index;
		logic [3:0]  col_index;
		logic [31:0] data_value;
		bit          typed;
		outcome_t    res;
	} request_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic        [2:0]  cmd;
	logic        [5:0]  row_index;
	logic        [3:0]  col_index;
	logic signed [31:0] data_value;
	logic               out_valid;
	logic               out_stall;
	logic        [1:0]  status;
	logic        [5:0]  found_row;
	logic        [3:0]  found_col;
	logic signed [31:0] old_value;

	jagged_row_table_engine DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .row_index(row_index), .col_index(col_index),
		.data_value(data_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .found_row(found_row), .found_col(found_col),
		.old_value(old_value)
	);

	// Our own copy of the table: entries, row lengths and the row count.
	logic [31:0] cells [0:CAP*ROWS-1];
	int          row_len [0:ROWS-1];
	int          rows_used;

	outcome_t    pending_results [$];
	int          errors;
	int          results_seen;
	int          status_tally [0:3];
	int          full_hits;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// A hard ceiling, far above the slowest legal run, in case the block hangs.
	initial begin
		#200ms;
		$display("jagged_row_table_engine: mismatch");
		$finish;
	end

	// Applies one request to the table copy and works out the result it owes.
	function automatic outcome_t table_apply(request_t rq);
		outcome_t o;
		int       base, len;
		bit       in_range;
		o = '{ST_OK, 6'd0, 4'd0, 32'd0};
		in_range = (rq.row_index < rows_used) && (rq.col_index < row_len[rq.row_index]);
		case (rq.cmd)
			CMD_FIND: begin
				o.status = ST_NOTFOUND;
				for (int i = 0; i < rows_used && o.status != ST_OK; i++) begin
					for (int j = 0; j < row_len[i]; j++) begin
						if (cells[i*CAP+j] == rq.data_value) begin
							o.status    = ST_OK;
							o.found_row = i[5:0];
							o.found_col = j[3:0];
							break;
						end
					end
				end
			end
			CMD_MODIFY: begin
				if (!in_range) begin
					o.status = ST_RANGE;
				end else begin
					o.old_value = cells[rq.row_index*CAP+rq.col_index];
					cells[rq.row_index*CAP+rq.col_index] = rq.data_value;
				end
			end
			CMD_APPEND: begin
				if (rows_used > 0 && row_len[rows_used-1] < CAP) begin
					cells[(rows_used-1)*CAP+row_len[rows_used-1]] = rq.data_value;
					row_len[rows_used-1]++;
				end else if (rows_used >= ROWS) begin
					o.status = ST_FULL;
				end else begin
					cells[rows_used*CAP] = rq.data_value;
					row_len[rows_used]   = 1;
					rows_used++;
				end
			end
			CMD_ZERO: begin
				if (!in_range)
					o.status = ST_RANGE;
				else
					cells[rq.row_index*CAP+rq.col_index] = 32'd0;
			end
			CMD_REMOVE: begin
				if (!in_range) begin
					o.status = ST_RANGE;
				end else begin
					base = rq.row_index * CAP;
					len  = row_len[rq.row_index];
					// Close the gap inside the row, then clear the freed slot.
					for (int j = rq.col_index; j + 1 < len; j++)
						cells[base+j] = cells[base+j+1];
					cells[base+len-1] = 32'd0;
					row_len[rq.row_index] = len - 1;
					// An emptied row is dropped and the later rows move up.
					if (len == 1) begin
						for (int i = rq.row_index; i + 1 < rows_used; i++) begin
							for (int j = 0; j < CAP; j++)
								cells[i*CAP+j] = cells[(i+1)*CAP+j];
							row_len[i] = row_len[i+1];
						end
						for (int j = 0; j < CAP; j++)
							cells[(rows_used-1)*CAP+j] = 32'd0;
						row_len[rows_used-1] = 0;
						rows_used--;
					end
				end
			end
			default: o.status = ST_RANGE;
		endcase
		return o;
	endfunction

	// Values come mostly from a small pool so that finds hit, plus the extremes.
	function automatic logic [31:0] pick_value();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50)
			return 32'($signed($urandom_range(0, 15)) - 8);
		else if (sel < 70)
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'hffff_ffff;
				default: return 32'h0;
			endcase
		return $urandom;
	endfunction

	// Random request. Appends dominate until the table has been seen full a few
	// times; after that the mix leans towards removal so the table drains.
	function automatic request_t random_request();
		request_t rq;
		int       sel, r;
		rq.typed      = 1'b0;
		rq.res        = '{ST_OK, 6'd0, 4'd0, 32'd0};
		rq.data_value = pick_value();
		sel = $urandom_range(0, 99);
		if (full_hits < 4) begin
			if (sel < 86)      rq.cmd = CMD_APPEND;
			else if (sel < 90) rq.cmd = CMD_FIND;
			else if (sel < 94) rq.cmd = CMD_MODIFY;
			else if (sel < 96) rq.cmd = CMD_ZERO;
			else if (sel < 98) rq.cmd = CMD_REMOVE;
			else               rq.cmd = 3'($urandom_range(5, 7));
		end else begin
			if (sel < 45)      rq.cmd = CMD_REMOVE;
			else if (sel < 60) rq.cmd = CMD_APPEND;
			else if (sel < 75) rq.cmd = CMD_FIND;
			else if (sel < 87) rq.cmd = CMD_MODIFY;
			else if (sel < 96) rq.cmd = CMD_ZERO;
			else               rq.cmd = 3'($urandom_range(5, 7));
		end
		if (rows_used > 0 && $urandom_range(0, 99) < 88)
			r = $urandom_range(0, rows_used - 1);
		else
			r = $urandom_range(0, 63);
		rq.row_index = r[5:0];
		if (row_len[r] > 0 && $urandom_range(0, 99) < 88)
			rq.col_index = 4'($urandom_range(0, row_len[r] - 1));
		else
			rq.col_index = 4'($urandom_range(0, 15));
		// Finds mostly look for a value that is actually in the table.
		if (rq.cmd == CMD_FIND && rows_used > 0 && row_len[r] > 0 &&
			$urandom_range(0, 99) < 60)
			rq.data_value = cells[r*CAP + $urandom_range(0, row_len[r] - 1)];
		return rq;
	endfunction

	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55) return 0;
		if (sel < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Drives one request and waits for it to be taken, then books its result.
	task automatic send_request(request_t rq);
		outcome_t predicted;
		int       gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= rq.cmd;
		row_index  <= rq.row_index;
		col_index  <= rq.col_index;
		data_value <= rq.data_value;
		do @(posedge clk); while (in_stall);
		predicted = table_apply(rq);
		if (rq.cmd == CMD_APPEND && predicted.status == ST_FULL)
			full_hits++;
		if (rq.typed)
			predicted = rq.res;
		pending_results = {pending_results, predicted};
	endtask

	// The directed table. Rows with a typed result are the ones that can be read
	// off at once: an empty table, a value not in the table, bad indices and unknown commands.
	request_t directed [N_DIRECT];
	initial begin
		directed = '{
			'{CMD_FIND,   6'd0,  4'd0,  32'h0,        1, '{ST_NOTFOUND, 0, 0, 0}},
			'{CMD_MODIFY, 6'd0,  4'd0,  32'h5,        1, '{ST_RANGE, 0, 0, 0}},
			'{CMD_ZERO,   6'd0,  4'd0,  32'h0,        1, '{ST_RANGE, 0, 0, 0}},
			'{CMD_REMOVE, 6'd0,  4'd0,  32'h0,        1, '{ST_RANGE, 0, 0, 0}},
			'{CMD_BAD5,   6'd63, 4'd15, 32'hffff_ffff, 1, '{ST_RANGE, 0, 0, 0}},
			'{CMD_BAD6,   6'd0,  4'd0,  32'h8000_0000, 1, '{ST_RANGE, 0, 0, 0}},
			'{CMD_BAD7,   6'd42, 4'd9,  32'h7fff_ffff, 1, '{ST_RANGE, 0, 0, 0}},
			'{CMD_APPEND, 6'd0,  4'd0,  32'h8000_0000, 0, '{ST_OK, 0, 0, 0}},
			'{CMD_APPEND, 6'd63, 4'd15, 32'h7fff_ffff, 0, '{ST_OK, 0, 0, 0}},
			'{CMD_APPEND, 6'd0,  4'd0,  32'h0,        0, '{ST_OK, 0, 0, 0}},
			'{CMD_APPEND, 6'd0,  4'd0,  32'hffff_ffff, 0, '{ST_OK, 0, 0, 0}},
			'{CMD_FIND,   6'd0,  4'd0,  32'h7fff_ffff, 0, '{ST_OK, 0, 0, 0}},
			'{CMD_FIND,   6'd0,  4'd0,  32'h1234_5678, 1, '{ST_NOTFOUND, 0, 0, 0}},
			'{CMD_MODIFY, 6'd0,  4'd1,  32'h0000_0001, 0, '{ST_OK, 0, 0, 0}},
			'{CMD_MODIFY, 6'd0,  4'd4,  32'h0,        1, '{ST_RANGE, 0, 0, 0}},
			'{CMD_MODIFY, 6'd63, 4'd15, 32'h0,        1, '{ST_RANGE, 0, 0, 0}},
			'{CMD_ZERO,   6'd1,  4'd0,  32'h0,        1, '{ST_RANGE, 0, 0, 0}},
			'{CMD_ZERO,   6'd0,  4'd0,  32'h0,        0, '{ST_OK, 0, 0, 0}},
			'{CMD_FIND,   6'd0,  4'd0,  32'h0,        0, '{ST_OK, 0, 0, 0}},
			'{CMD_REMOVE, 6'd0,  4'd1,  32'h0,        0, '{ST_OK, 0, 0, 0}},
			'{CMD_REMOVE, 6'd0,  4'd3,  32'h0,        1, '{ST_RANGE, 0, 0, 0}},
			'{CMD_REMOVE, 6'd0,  4'd0,  32'h0,        0, '{ST_OK, 0, 0, 0}},
			'{CMD_REMOVE, 6'd0,  4'd1,  32'h0,        0, '{ST_OK, 0, 0, 0}},
			// The row has one entry left; this removal drops the whole row.
			'{CMD_REMOVE, 6'd0,  4'd0,  32'h0,        0, '{ST_OK, 0, 0, 0}}
		};
	end

	// Receiver: stretches of free flow broken by stalls, a few of them long.
	initial begin
		int n;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(0, 99) < 10 ? $urandom_range(10, 60) : $urandom_range(0, 3);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 25)) @(posedge clk);
		end
	end

	// Each result that is taken is held against the oldest one still owed.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with no request outstanding, status %0d", $time, status);
			end else begin
				want = pending_results.pop_front();
				status_tally[want.status]++;
				if (status !== want.status) begin
					errors++;
					$display("%0t: status expected %0d got %0d", $time, want.status, status);
				end
				if (found_row !== want.found_row) begin
					errors++;
					$display("%0t: found_row expected %0d got %0d",
						$time, want.found_row, found_row);
				end
				if (found_col !== want.found_col) begin
					errors++;
					$display("%0t: found_col expected %0d got %0d",
						$time, want.found_col, found_col);
				end
				if (old_value !== want.old_value) begin
					errors++;
					$display("%0t: old_value expected %h got %h",
						$time, want.old_value, old_value);
				end
			end
		end
	end

	// Main sequence: reset, directed table, random requests, then drain.
	initial begin
		int waited;
		errors        = 0;
		results_seen  = 0;
		full_hits     = 0;
		status_tally  = '{0, 0, 0, 0};
		rows_used     = 0;
		for (int k = 0; k < CAP*ROWS; k++) cells[k] = 32'd0;
		for (int k = 0; k < ROWS; k++) row_len[k] = 0;
		arst_n     = 1'b0;
		in_valid   <= 1'b0;
		cmd        <= CMD_FIND;
		row_index  <= 6'd0;
		col_index  <= 4'd0;
		data_value <= 32'sd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < N_DIRECT; k++)
			send_request(directed[k]);
		for (int k = 0; k < N_RANDOM; k++)
			send_request(random_request());
		in_valid <= 1'b0;

		waited = 0;
		while (pending_results.size() > 0 && waited < 2_000_000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);

		$display("Ran %0d requests, %0d results: %0d ok, %0d not found, %0d out of range,",
			N_DIRECT + N_RANDOM, results_seen, status_tally[ST_OK],
			status_tally[ST_NOTFOUND], status_tally[ST_RANGE]);
		$display("%0d table full; %0d rows in use at the end.",
			status_tally[ST_FULL], rows_used);
		if (errors == 0 && pending_results.size() == 0)
			$display("jagged_row_table_engine: match");
		else
			$display("jagged_row_table_engine: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
